@@ rtl/time_tagged_slot_cache_lru_macros.svh @@
// Assertion macros used by the slot cache checker.
// No dependencies; include by bare file name.
`ifndef TIME_TAGGED_SLOT_CACHE_LRU_MACROS_SVH
`define TIME_TAGGED_SLOT_CACHE_LRU_MACROS_SVH

// same-cycle implication, gated by reset
`define TTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define TTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ttsc_pkg.sv @@
// Types, widths and operation codes of the time-tagged slot cache.
// No dependencies; used by all files but ttsc_ram and the macro header.
package ttsc_pkg;

    localparam int FUNC_W  = 3;
    localparam int TIME_W  = 32;
    localparam int GEN_W   = 16;
    localparam int FRAME_W = 32;
    localparam int SLOT_W  = 5;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [GEN_W-1:0]   t_gen;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [SLOT_W-1:0]  t_slot;

    localparam t_func FUNC_FIND     = 3'd0;
    localparam t_func FUNC_ALLOC    = 3'd1;
    localparam t_func FUNC_CLAIM    = 3'd2;
    localparam t_func FUNC_FILL     = 3'd3;
    localparam t_func FUNC_TOUCH    = 3'd4;
    localparam t_func FUNC_NEWFRAME = 3'd5;
    localparam t_func FUNC_INVALL   = 3'd6;
    localparam t_func FUNC_CLEARALL = 3'd7;

    typedef struct packed {
        logic exec;
        logic step;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic last_addr;
    } t_ctl_sts;

endpackage

@@ rtl/ttsc_req_if.sv @@
// Request channel of the slot cache: valid/ready plus request fields.
// Depends on ttsc_pkg.
interface ttsc_req_if;
    import ttsc_pkg::*;

    logic  valid;
    logic  ready;
    t_func func;
    t_time tag_time;
    t_time tolerance;
    t_slot slot_index;

    modport source (output valid, func, tag_time, tolerance, slot_index, input ready);
    modport sink   (input valid, func, tag_time, tolerance, slot_index, output ready);
endinterface

@@ rtl/ttsc_rsp_if.sv @@
// Result channel of the slot cache: valid/ready plus result fields.
// Depends on ttsc_pkg.
interface ttsc_rsp_if;
    import ttsc_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    t_slot slot_out;
    logic  current_gen;
    logic  evicted;

    modport source (output valid, found, slot_out, current_gen, evicted, input ready);
    modport sink   (input valid, found, slot_out, current_gen, evicted, output ready);
endinterface

@@ rtl/time_tagged_slot_cache_lru.sv @@
// Top level of the time-tagged slot cache with LRU replacement.
// Depends on ttsc_pkg, ttsc_req_if, ttsc_rsp_if, ttsc_ctrl and ttsc_dp.
//
// Fully associative cache of NUM_SLOTS slots, each holding a Q16.16 time tag,
// generation and last-use frame in two single-read-port RAMs, with valid and
// per-frame claim bits in flip-flops. Every request yields exactly one result.
// Find and allocate sweep the slot RAMs one slot per cycle, then drain the
// last read before committing; claim, fill, touch, new frame, invalidate all
// and clear all skip the sweep and go straight to commit. One request
// is in work at a time; the result sits in its own register, so the next
// request is taken while the previous result still waits on o_rsp.ready.
// No clearing pass after reset: slot contents are only read once written.
module time_tagged_slot_cache_lru #(
    parameter int NUM_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttsc_req_if.sink    i_req,
    ttsc_rsp_if.source  o_rsp
);
    import ttsc_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    ttsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ttsc_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_func        (i_req.func),
        .i_tag_time    (i_req.tag_time),
        .i_tolerance   (i_req.tolerance),
        .i_slot_index  (i_req.slot_index),
        .o_found       (o_rsp.found),
        .o_slot_out    (o_rsp.slot_out),
        .o_current_gen (o_rsp.current_gen),
        .o_evicted     (o_rsp.evicted)
    );
endmodule

@@ rtl/ttsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/ttsc_ctrl.sv @@
// Sequencer of the slot cache: request intake, slot sweep, result hand-off.
// Depends on ttsc_pkg; drives the datapath through t_ctl_cmd.
module ttsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  ttsc_pkg::t_func     i_req_func,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    input  ttsc_pkg::t_ctl_sts  i_sts,
    output ttsc_pkg::t_ctl_cmd  o_cmd
);
    import ttsc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       w_scan_op;

    always_comb begin
        w_scan_op   = (i_req_func == FUNC_FIND) || (i_req_func == FUNC_ALLOC);
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = w_scan_op ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_rsp_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_rsp_valid = r_out_vld;
endmodule

@@ rtl/ttsc_dp.sv @@
// Datapath of the slot cache: slot RAMs, valid and claim bits, sweep trackers
// and the result register. Depends on ttsc_pkg and ttsc_ram.
module ttsc_dp #(
    parameter int NUM_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttsc_pkg::t_ctl_cmd i_cmd,
    output ttsc_pkg::t_ctl_sts o_sts,
    input  ttsc_pkg::t_func    i_func,
    input  ttsc_pkg::t_time    i_tag_time,
    input  ttsc_pkg::t_time    i_tolerance,
    input  ttsc_pkg::t_slot    i_slot_index,
    output logic               o_found,
    output ttsc_pkg::t_slot    o_slot_out,
    output logic               o_current_gen,
    output logic               o_evicted
);
    import ttsc_pkg::*;

    localparam int IW  = $clog2(NUM_SLOTS);
    localparam int XW  = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int CW  = XW + 1;
    localparam int TGW = GEN_W + TIME_W;

    function automatic t_slot to_slot(input logic [IW-1:0] idx);
        logic [XW-1:0] ext;
        ext = XW'(idx);
        return ext[SLOT_W-1:0];
    endfunction

    // request capture
    t_func   r_op;
    t_time   r_tag;
    t_time   r_tol;

    // global state
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] n_valid;
    logic [NUM_SLOTS-1:0] r_claimed;
    logic [NUM_SLOTS-1:0] n_claimed;
    t_gen    r_gen_now;
    t_frame  r_frame_now;

    // sweep
    logic [IW-1:0] r_rd_addr;
    logic [IW-1:0] r_chk_idx;
    logic          r_chk_vld;

    // trackers
    logic          r_hit_cur;
    logic [IW-1:0] r_cur_idx;
    logic          r_hit_stale;
    logic [IW-1:0] r_stale_idx;
    logic          r_have_free;
    logic [IW-1:0] r_free_idx;
    logic          r_have_best;
    logic [IW-1:0] r_best_idx;
    t_frame        r_best_last;

    // result register
    logic    r_found;
    t_slot   r_slot;
    logic    r_cur;
    logic    r_evict;

    // request decode
    logic [XW-1:0] w_idx_ext;
    logic [IW-1:0] w_waddr;
    logic          w_idx_ok;
    logic          w_we_tg;
    logic          w_we_last;

    // RAM read side
    logic [TGW-1:0] w_rd_tg;
    t_time          w_rd_time;
    t_gen           w_rd_gen;
    t_frame         w_rd_last;

    // slot evaluation
    logic   w_chk_valid;
    logic   w_chk_claimed;
    t_time  w_diff_a;
    t_time  w_diff_b;
    t_time  w_abs;
    logic   w_match;
    logic   w_gen_eq;
    logic   w_hit;
    logic   w_free;
    logic   w_better;
    logic   w_evict_now;

    assign w_idx_ext = XW'(i_slot_index);
    assign w_waddr   = w_idx_ext[IW-1:0];
    assign w_idx_ok  = {1'b0, w_idx_ext} < CW'(NUM_SLOTS);
    assign w_we_tg   = i_cmd.exec && (i_func == FUNC_FILL) && w_idx_ok;
    assign w_we_last = i_cmd.exec && w_idx_ok
                       && ((i_func == FUNC_FILL) || (i_func == FUNC_TOUCH));

    ttsc_ram #(
        .WIDTH (TGW),
        .DEPTH (NUM_SLOTS)
    ) u_tg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_tg),
        .i_waddr (w_waddr),
        .i_wdata ({r_gen_now, i_tag_time}),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_tg)
    );

    ttsc_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_SLOTS)
    ) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_last),
        .i_waddr (w_waddr),
        .i_wdata (r_frame_now),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_last)
    );

    assign w_rd_time = w_rd_tg[TIME_W-1:0];
    assign w_rd_gen  = w_rd_tg[TGW-1:TIME_W];

    assign o_sts.last_addr = (r_rd_addr == IW'(NUM_SLOTS - 1));

    always_comb begin
        w_chk_valid   = r_valid[r_chk_idx];
        w_chk_claimed = r_claimed[r_chk_idx];
        w_diff_a      = w_rd_time - r_tag;
        w_diff_b      = r_tag - w_rd_time;
        w_abs         = (w_rd_time >= r_tag) ? w_diff_a : w_diff_b;
        w_match       = w_abs < r_tol;
        w_gen_eq      = (w_rd_gen == r_gen_now);
        w_hit         = r_chk_vld && !w_chk_claimed && w_chk_valid && w_match;
        w_free        = r_chk_vld && !w_chk_claimed && !w_chk_valid;
        w_better      = r_chk_vld && !w_chk_claimed
                        && (!r_have_best || (w_rd_last < r_best_last));
        w_evict_now   = i_cmd.commit && (r_op == FUNC_ALLOC) && !r_have_free && r_have_best;
    end

    always_comb begin
        n_valid   = r_valid;
        n_claimed = r_claimed;
        if (i_cmd.exec) begin
            case (i_func)
                FUNC_CLAIM: begin
                    if (w_idx_ok) begin
                        n_claimed[w_waddr] = 1'b1;
                    end
                end
                FUNC_FILL: begin
                    if (w_idx_ok) begin
                        n_valid[w_waddr] = 1'b1;
                    end
                end
                FUNC_NEWFRAME: begin
                    n_claimed = '0;
                end
                FUNC_CLEARALL: begin
                    n_valid = '0;
                end
                default: begin
                end
            endcase
        end
        if (w_evict_now) begin
            n_valid[r_best_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_claimed   <= '0;
            r_gen_now   <= '0;
            r_frame_now <= '0;
            r_chk_vld   <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_claimed <= n_claimed;
            r_chk_vld <= i_cmd.step;
            if (i_cmd.exec) begin
                case (i_func)
                    FUNC_NEWFRAME: r_frame_now <= r_frame_now + FRAME_W'(1);
                    FUNC_INVALL:   r_gen_now   <= r_gen_now + GEN_W'(1);
                    FUNC_CLEARALL: r_gen_now   <= '0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_op        <= i_func;
            r_tag       <= i_tag_time;
            r_tol       <= i_tolerance;
            r_rd_addr   <= '0;
            r_hit_cur   <= 1'b0;
            r_hit_stale <= 1'b0;
            r_have_free <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_rd_addr <= r_rd_addr + IW'(1);
            end
            if (w_hit && w_gen_eq && !r_hit_cur) begin
                r_hit_cur <= 1'b1;
                r_cur_idx <= r_chk_idx;
            end
            if (w_hit && !w_gen_eq && !r_hit_stale) begin
                r_hit_stale <= 1'b1;
                r_stale_idx <= r_chk_idx;
            end
            if (w_free && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_chk_idx;
            end
            if (w_better) begin
                r_have_best <= 1'b1;
                r_best_idx  <= r_chk_idx;
                r_best_last <= w_rd_last;
            end
        end
        r_chk_idx <= r_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_found <= 1'b0;
            r_slot  <= '0;
            r_cur   <= 1'b0;
            r_evict <= 1'b0;
            case (r_op)
                FUNC_FIND: begin
                    if (r_hit_cur) begin
                        r_found <= 1'b1;
                        r_slot  <= to_slot(r_cur_idx);
                        r_cur   <= 1'b1;
                    end else if (r_hit_stale) begin
                        r_found <= 1'b1;
                        r_slot  <= to_slot(r_stale_idx);
                    end
                end
                FUNC_ALLOC: begin
                    if (r_have_free) begin
                        r_found <= 1'b1;
                        r_slot  <= to_slot(r_free_idx);
                    end else if (r_have_best) begin
                        r_found <= 1'b1;
                        r_slot  <= to_slot(r_best_idx);
                        r_evict <= r_valid[r_best_idx];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_found       = r_found;
    assign o_slot_out    = r_slot;
    assign o_current_gen = r_cur;
    assign o_evicted     = r_evict;
endmodule

@@ rtl/ttsc_checker.sv @@
// Port-level checker for the slot cache, bound to the top level.
// Depends on ttsc_pkg and time_tagged_slot_cache_lru_macros.svh.
`include "time_tagged_slot_cache_lru_macros.svh"

module ttsc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input logic            i_found,
    input ttsc_pkg::t_slot i_slot_out,
    input logic            i_current_gen,
    input logic            i_evicted
);
    import ttsc_pkg::*;

    `TTSC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_found) && $stable(i_slot_out) && $stable(i_current_gen) && $stable(i_evicted), "stalled result changed")
    `TTSC_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && !i_found, (i_slot_out == '0) && !i_current_gen && !i_evicted, "miss result not all zero")
    `TTSC_ASSERT_NOW(a_flag_excl, i_clk, i_rst_n, i_rsp_valid && (i_current_gen || i_evicted), i_found && !(i_current_gen && i_evicted), "current and evicted flags clash")
    `TTSC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")
endmodule

bind time_tagged_slot_cache_lru ttsc_checker u_ttsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_slot_out    (o_rsp.slot_out),
    .i_current_gen (o_rsp.current_gen),
    .i_evicted     (o_rsp.evicted)
);
